// ----- design/sphere_surface_distance_assert.svh -----
// Assertion macros for the sphere surface distance block.
`ifndef SPHERE_SURFACE_DISTANCE_ASSERT_SVH
`define SPHERE_SURFACE_DISTANCE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define SSD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define SSD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/ssd_pkg.sv -----
// Shared types and constants for the sphere surface distance block.
package ssd_pkg;

	localparam int CfgIndexWidth = 3;

	typedef enum logic [CfgIndexWidth-1:0] {
		CFG_CENTER_X = 3'd0,
		CFG_CENTER_Y = 3'd1,
		CFG_CENTER_Z = 3'd2,
		CFG_RADIUS   = 3'd3,
		CFG_INWARD   = 3'd4
	} cfg_idx_t;

endpackage

// ----- design/ssd_in_if.sv -----
// Particle position channel: valid, ready and one position per beat.
interface ssd_in_if #(parameter int W = 32);
	logic         valid;
	logic         ready;
	logic [W-1:0] particle_x;
	logic [W-1:0] particle_y;
	logic [W-1:0] particle_z;

	modport source (output valid, particle_x, particle_y, particle_z, input ready);
	modport sink (input valid, particle_x, particle_y, particle_z, output ready);
endinterface

// ----- design/ssd_out_if.sv -----
// Result channel: valid, ready, distance, push vector and center flag per beat.
interface ssd_out_if #(parameter int W = 32);
	logic         valid;
	logic         ready;
	logic [W-1:0] surface_distance;
	logic [W-1:0] push_x;
	logic [W-1:0] push_y;
	logic [W-1:0] push_z;
	logic         at_center;

	modport source (output valid, surface_distance, push_x, push_y, push_z, at_center,
		input ready);
	modport sink (input valid, surface_distance, push_x, push_y, push_z, at_center,
		output ready);
endinterface

// ----- design/sphere_surface_distance.sv -----
// Signed distance from a particle to a spherical wall plus the push vector, Q16.16 by
// default. One position is taken per clock and one result leaves per clock; the square
// root adds one bit per stage over COORD_WIDTH+1 stages, the divider one quotient bit
// per stage over COORD_WIDTH stages. The whole pipeline holds while a result waits at
// the output. Write the center, radius and side only while no particle is in flight.
// A particle at the center sets at_center and returns a zero push vector.
`include "sphere_surface_distance_assert.svh"

module sphere_surface_distance import ssd_pkg::*; #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	ssd_in_if.sink                   particle,
	ssd_out_if.source                result,
	input  logic                     cfg_we,
	input  logic [CfgIndexWidth-1:0] cfg_index,
	input  logic [COORD_WIDTH-1:0]   cfg_data
);
	localparam int W  = COORD_WIDTH;
	localparam int DW = W + 1;
	localparam int SW = 2 * DW;
	localparam int GW = DW + 1;
	localparam int XPW = GW + 2;

	localparam logic signed [GW-1:0] GMax = GW'((64'd1 << (W - 1)) - 64'd1);
	localparam logic signed [GW-1:0] GMin = -GMax - GW'(1);
	localparam logic [W:0]           QMaxPos = (W+1)'((64'd1 << (W - 1)) - 64'd1);
	localparam logic [W:0]           QMaxNeg = (W+1)'(64'd1 << (W - 1));
	localparam logic [W-1:0]         WMax = GMax[W-1:0];
	localparam logic [W-1:0]         WMin = GMin[W-1:0];

	logic [W-1:0]   center_x_q, center_y_q, center_z_q;
	logic [W-2:0]   radius_q;
	logic           inward_q;

	logic           en;
	logic           out_v_q;

	logic                 v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [DW-1:0] d_s1 [3];
	logic signed [DW-1:0] d_s2 [3];
	logic [SW-1:0]        sq_s2 [3];
	logic signed [DW-1:0] d_s3 [3];
	logic [SW-1:0]        sum_s3;
	logic signed [DW-1:0] d_s4 [3];
	logic [DW-1:0]        len_s4;
	logic signed [GW-1:0] g_s4;
	logic [SW-1:0]        prod_s5 [3];
	logic [2:0]           neg_s5;
	logic signed [GW-1:0] g_s5;
	logic [DW-1:0]        len_s5;
	logic                 zero_s5;

	logic                 sq_v;
	logic [DW-1:0]        sq_root;
	logic [3*DW-1:0]      sq_pl;

	logic                 dv_v [3];
	logic [W-1:0]         dv_q [3];
	logic [DW:0]          dv_rem [3];
	logic                 dv_ovf [3];
	logic [DW-1:0]        dv_den [3];
	logic [XPW-1:0]       dx_pl;
	logic                 dy_pl, dz_pl;
	logic signed [GW-1:0] gx;
	logic                 zx;
	logic                 negs [3];

	function automatic logic [DW-1:0] mag_d(input logic signed [DW-1:0] v);
		return v[DW-1] ? DW'(-v) : DW'(v);
	endfunction

	function automatic logic [W-1:0] push_sat(input logic [W-1:0] q, input logic [DW:0] r,
			input logic [DW-1:0] den, input logic ovf, input logic neg);
		logic       up;
		logic [W:0] qr;
		up = r >= ({1'b0, den} - r);
		qr = {1'b0, q} + (W+1)'(up);
		if (neg) begin
			return (ovf || qr > QMaxNeg) ? WMin : W'(-qr);
		end
		return (ovf || qr > QMaxPos) ? WMax : qr[W-1:0];
	endfunction

	assign en             = !out_v_q || result.ready;
	assign particle.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			center_z_q <= '0;
			radius_q   <= (W-1)'(1) << FRAC_BITS;
			inward_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CENTER_X: center_x_q <= cfg_data;
				CFG_CENTER_Y: center_y_q <= cfg_data;
				CFG_CENTER_Z: center_z_q <= cfg_data;
				CFG_RADIUS:   radius_q   <= cfg_data[W-2:0];
				CFG_INWARD:   inward_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= particle.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= sq_v;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1[0] <= $signed({center_x_q[W-1], center_x_q})
				- $signed({particle.particle_x[W-1], particle.particle_x});
			d_s1[1] <= $signed({center_y_q[W-1], center_y_q})
				- $signed({particle.particle_y[W-1], particle.particle_y});
			d_s1[2] <= $signed({center_z_q[W-1], center_z_q})
				- $signed({particle.particle_z[W-1], particle.particle_z});
			for (int i = 0; i < 3; i++) begin
				d_s2[i]  <= d_s1[i];
				sq_s2[i] <= mag_d(d_s1[i]) * mag_d(d_s1[i]);
				d_s3[i]  <= d_s2[i];
			end
			sum_s3 <= sq_s2[0] + sq_s2[1] + sq_s2[2];
			len_s4 <= sq_root;
			g_s4   <= $signed({{(GW-W+1){1'b0}}, radius_q}) - $signed({1'b0, sq_root});
			for (int i = 0; i < 3; i++) begin
				d_s4[i] <= $signed(sq_pl[i*DW +: DW]);
			end
			for (int i = 0; i < 3; i++) begin
				prod_s5[i] <= mag_d(d_s4[i])
					* (g_s4[GW-1] ? DW'(-g_s4) : DW'(g_s4));
				neg_s5[i]  <= d_s4[i][DW-1] ^ g_s4[GW-1];
			end
			g_s5    <= g_s4;
			len_s5  <= len_s4;
			zero_s5 <= len_s4 == '0;
		end
	end

	ssd_sqrt #(.DW(DW), .PW(3*DW)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s3), .radicand(sum_s3), .in_payload({d_s3[2], d_s3[1], d_s3[0]}),
		.out_valid(sq_v), .root(sq_root), .out_payload(sq_pl)
	);

	ssd_div #(.W(W), .PW(XPW)) u_div_x (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s5), .numer(prod_s5[0]), .denom(len_s5),
		.in_payload({neg_s5[0], g_s5, zero_s5}),
		.out_valid(dv_v[0]), .quot(dv_q[0]), .rem(dv_rem[0]), .ovf(dv_ovf[0]),
		.den_out(dv_den[0]), .out_payload(dx_pl)
	);

	ssd_div #(.W(W), .PW(1)) u_div_y (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s5), .numer(prod_s5[1]), .denom(len_s5), .in_payload(neg_s5[1]),
		.out_valid(dv_v[1]), .quot(dv_q[1]), .rem(dv_rem[1]), .ovf(dv_ovf[1]),
		.den_out(dv_den[1]), .out_payload(dy_pl)
	);

	ssd_div #(.W(W), .PW(1)) u_div_z (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s5), .numer(prod_s5[2]), .denom(len_s5), .in_payload(neg_s5[2]),
		.out_valid(dv_v[2]), .quot(dv_q[2]), .rem(dv_rem[2]), .ovf(dv_ovf[2]),
		.den_out(dv_den[2]), .out_payload(dz_pl)
	);

	assign negs[0] = dx_pl[XPW-1];
	assign negs[1] = dy_pl;
	assign negs[2] = dz_pl;
	assign gx      = $signed(dx_pl[GW:1]);
	assign zx      = dx_pl[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= dv_v[0] && dv_v[1] && dv_v[2];
		end
	end

	always_ff @(posedge clk) begin
		logic signed [GW-1:0] sdist;
		if (en) begin
			sdist = inward_q ? gx : -gx;
			result.surface_distance <= (sdist > GMax) ? WMax
				: (sdist < GMin) ? WMin : sdist[W-1:0];
			result.push_x    <= zx ? '0 : push_sat(dv_q[0], dv_rem[0], dv_den[0],
				dv_ovf[0], negs[0]);
			result.push_y    <= zx ? '0 : push_sat(dv_q[1], dv_rem[1], dv_den[1],
				dv_ovf[1], negs[1]);
			result.push_z    <= zx ? '0 : push_sat(dv_q[2], dv_rem[2], dv_den[2],
				dv_ovf[2], negs[2]);
			result.at_center <= zx;
		end
	end

	assign result.valid = out_v_q;

	`SSD_ASSERT_IMP(a_center_push_zero, result.valid && result.at_center, result.push_x == '0 && result.push_y == '0 && result.push_z == '0, "push not zero at center")
	`SSD_ASSERT_IMP(a_center_distance, result.valid && result.at_center, result.surface_distance == (inward_q ? {1'b0, radius_q} : W'(-{1'b0, radius_q})), "distance at center is not the radius")
	`SSD_ASSERT_NXT(a_stall_holds, result.valid && !result.ready, result.valid && !particle.ready == !result.ready, "stalled result dropped")
endmodule

// ----- design/ssd_sqrt.sv -----
// Pipelined integer square root, one result bit per stage.
module ssd_sqrt #(
	parameter int DW = 33,
	parameter int PW = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [2*DW-1:0]   radicand,
	input  logic [PW-1:0]     in_payload,
	output logic              out_valid,
	output logic [DW-1:0]     root,
	output logic [PW-1:0]     out_payload
);
	localparam int SW = 2 * DW;
	localparam int RW = DW + 2;

	logic          v_s   [1:DW];
	logic [RW-1:0] rem_s [1:DW];
	logic [DW-1:0] res_s [1:DW];
	logic [SW-1:0] rad_s [1:DW];
	logic [PW-1:0] pl_s  [1:DW];

	genvar k;
	for (k = 0; k < DW; k++) begin : g_step
		logic          v_in;
		logic [RW-1:0] rem_in;
		logic [DW-1:0] res_in;
		logic [SW-1:0] rad_in;
		logic [PW-1:0] pl_in;
		logic [RW-1:0] rem_sh;
		logic [RW-1:0] trial;

		if (k == 0) begin : g_first
			assign v_in   = in_valid;
			assign rem_in = '0;
			assign res_in = '0;
			assign rad_in = radicand;
			assign pl_in  = in_payload;
		end else begin : g_next
			assign v_in   = v_s[k];
			assign rem_in = rem_s[k];
			assign res_in = res_s[k];
			assign rad_in = rad_s[k];
			assign pl_in  = pl_s[k];
		end

		assign rem_sh = {rem_in[RW-3:0], rad_in[SW-1 -: 2]};
		assign trial  = {res_in, 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_sh >= trial) begin
					rem_s[k+1] <= rem_sh - trial;
					res_s[k+1] <= {res_in[DW-2:0], 1'b1};
				end else begin
					rem_s[k+1] <= rem_sh;
					res_s[k+1] <= {res_in[DW-2:0], 1'b0};
				end
				rad_s[k+1] <= {rad_in[SW-3:0], 2'b00};
				pl_s[k+1]  <= pl_in;
			end
		end
	end

	assign out_valid   = v_s[DW];
	assign root        = res_s[DW];
	assign out_payload = pl_s[DW];
endmodule

// ----- design/ssd_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
module ssd_div #(
	parameter int W  = 32,
	parameter int PW = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [2*(W+1)-1:0]  numer,
	input  logic [W:0]          denom,
	input  logic [PW-1:0]       in_payload,
	output logic                out_valid,
	output logic [W-1:0]        quot,
	output logic [W+1:0]        rem,
	output logic                ovf,
	output logic [W:0]          den_out,
	output logic [PW-1:0]       out_payload
);
	localparam int DW = W + 1;
	localparam int RW = DW + 1;

	logic          v_s   [1:W];
	logic [RW-1:0] rem_s [1:W];
	logic [W-1:0]  q_s   [1:W];
	logic [W-1:0]  low_s [1:W];
	logic          ovf_s [1:W];
	logic [DW-1:0] den_s [1:W];
	logic [PW-1:0] pl_s  [1:W];

	genvar k;
	for (k = 0; k < W; k++) begin : g_step
		logic          v_in;
		logic [RW-1:0] rem_in;
		logic [W-1:0]  q_in;
		logic [W-1:0]  low_in;
		logic          ovf_in;
		logic [DW-1:0] den_in;
		logic [PW-1:0] pl_in;
		logic [RW-1:0] rem_sh;
		logic [RW-1:0] den_x;

		if (k == 0) begin : g_first
			assign v_in   = in_valid;
			assign rem_in = numer[2*DW-1 -: RW];
			assign q_in   = '0;
			assign low_in = numer[W-1:0];
			assign ovf_in = numer[2*DW-1 -: RW] >= {1'b0, denom};
			assign den_in = denom;
			assign pl_in  = in_payload;
		end else begin : g_next
			assign v_in   = v_s[k];
			assign rem_in = rem_s[k];
			assign q_in   = q_s[k];
			assign low_in = low_s[k];
			assign ovf_in = ovf_s[k];
			assign den_in = den_s[k];
			assign pl_in  = pl_s[k];
		end

		assign rem_sh = {rem_in[RW-2:0], low_in[W-1]};
		assign den_x  = {1'b0, den_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_sh >= den_x) begin
					rem_s[k+1] <= rem_sh - den_x;
					q_s[k+1]   <= {q_in[W-2:0], 1'b1};
				end else begin
					rem_s[k+1] <= rem_sh;
					q_s[k+1]   <= {q_in[W-2:0], 1'b0};
				end
				low_s[k+1] <= {low_in[W-2:0], 1'b0};
				ovf_s[k+1] <= ovf_in;
				den_s[k+1] <= den_in;
				pl_s[k+1]  <= pl_in;
			end
		end
	end

	assign out_valid   = v_s[W];
	assign quot        = q_s[W];
	assign rem         = rem_s[W];
	assign ovf         = ovf_s[W];
	assign den_out     = den_s[W];
	assign out_payload = pl_s[W];
endmodule
